>>> hdl/ukt_pkg.sv
// Package for the unique-key table: request and result types, command,
// status and sequencer state codes, and fixed field widths.
// No dependencies.
`default_nettype none

package ukt_pkg;

  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  localparam int FIDX_W = 6;
  localparam int ECNT_W = 7;
  localparam int ENTRY_W = KEY_W + PAY_W;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_REPLACE = 2'd3
  } ukt_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } ukt_status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2,
    S_RESP  = 2'd3
  } ukt_state_t;

  typedef struct packed {
    ukt_cmd_t           command;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } ukt_in_t;

  typedef struct packed {
    ukt_status_t        status;
    logic [PAY_W-1:0]   found_payload;
    logic [FIDX_W-1:0]  found_index;
    logic [ECNT_W-1:0]  entry_count;
  } ukt_out_t;

endpackage

`default_nettype wire

>>> hdl/ukt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ukt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/ukt_ctrl.sv
// Sequencer for the unique-key table: linear key scan and compaction shift
// over the entry RAM, plus the entry count. Depends on ukt_pkg.
`default_nettype none

module ukt_ctrl
  import ukt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ukt_in_t                     in_data,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output ukt_out_t                         res_data,
  output logic                             ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0]      ram_wr_addr,
  output logic [ENTRY_W-1:0]               ram_wr_data,
  output logic                             ram_rd_en,
  output logic [$clog2(CAPACITY)-1:0]      ram_rd_addr,
  input  wire logic [ENTRY_W-1:0]          ram_rd_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  ukt_state_t         state_r, state_nxt;
  ukt_cmd_t           cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  ukt_status_t        status_r, status_nxt;
  logic [PAY_W-1:0]   fpay_r, fpay_nxt;
  logic [FIDX_W-1:0]  fidx_r, fidx_nxt;

  logic [KEY_W-1:0]        rd_key;
  logic [PAY_W-1:0]        rd_pay;
  logic [CNT_W-1:0]        idx_ext;
  logic [CNT_W-1:0]        next_pos;
  logic [CNT_W-1:0]        shift_next;
  logic [IDX_W+FIDX_W-1:0] idx_wide;
  logic [CNT_W+ECNT_W-1:0] cnt_wide;
  logic                    hit;
  logic                    last;

  assign rd_key     = ram_rd_data[ENTRY_W-1:PAY_W];
  assign rd_pay     = ram_rd_data[PAY_W-1:0];
  assign idx_ext    = CNT_W'(idx_r);
  assign next_pos   = idx_ext + CNT_W'(1);
  assign shift_next = idx_ext + CNT_W'(2);
  assign idx_wide   = (IDX_W + FIDX_W)'(idx_r);
  assign cnt_wide   = (CNT_W + ECNT_W)'(cnt_r);
  assign hit        = (cnt_r != '0) && (rd_key == key_r);
  assign last       = (next_pos >= cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    fpay_r   <= fpay_nxt;
    fidx_r   <= fidx_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    pay_nxt     = pay_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    fpay_nxt    = fpay_r;
    fidx_nxt    = fidx_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = {rd_key, pay_r};

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt    = in_data.command;
          key_nxt    = in_data.key;
          pay_nxt    = in_data.payload;
          idx_nxt    = '0;
          status_nxt = ST_OK;
          fpay_nxt   = '0;
          fidx_nxt   = '0;
          ram_rd_en  = 1'b1;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        // The read of the following entry is always in flight during a scan,
        // so a remove hit can start shifting on the next cycle.
        ram_rd_en   = 1'b1;
        ram_rd_addr = next_pos[IDX_W-1:0];
        if (hit) begin
          fidx_nxt = idx_wide[FIDX_W-1:0];
          unique case (cmd_r)
            CMD_LOOKUP: begin
              fpay_nxt  = rd_pay;
              state_nxt = S_RESP;
            end
            CMD_ADD: begin
              status_nxt = ST_DUPLICATE;
              state_nxt  = S_RESP;
            end
            CMD_REPLACE: begin
              ram_wr_en = 1'b1;
              state_nxt = S_RESP;
            end
            CMD_REMOVE: begin
              if (last) begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end else if (last) begin
          state_nxt = S_RESP;
          if (cmd_r == CMD_ADD) begin
            if (cnt_r >= CAP_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = cnt_r[IDX_W-1:0];
              ram_wr_data = {key_r, pay_r};
              fidx_nxt    = cnt_wide[FIDX_W-1:0];
              cnt_nxt     = cnt_r + CNT_W'(1);
            end
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end else begin
          idx_nxt = next_pos[IDX_W-1:0];
        end
      end

      S_SHIFT: begin
        // idx_r is the destination; the read data holds the entry above it.
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
        if (shift_next >= cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = shift_next[IDX_W-1:0];
          idx_nxt     = next_pos[IDX_W-1:0];
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_data.status        = status_r;
    res_data.found_payload = fpay_r;
    res_data.found_index   = fidx_r;
    res_data.entry_count   = cnt_wide[ECNT_W-1:0];
  end

`ifndef SYNTHESIS
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      ((cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r + CNT_W'(1) == $past(cnt_r))))
    else $error("entry count moved by more than one");

  a_cnt_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (state_r == S_RESP))
    else $error("entry count changed before the result was ready");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ((state_r == S_SCAN) || (state_r == S_SHIFT)))
    else $error("entry RAM written outside scan or shift");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RESP) && (status_r == ST_FULL)) |-> (cnt_r == CAP_CNT))
    else $error("full status reported with room left");
`endif

endmodule

`default_nettype wire

>>> hdl/unique_key_table_compacting_unit.sv
// Top level of the unique-key table: sequencer, entry RAM and result buffer.
// Depends on ukt_pkg, ukt_ram and ukt_ctrl.
//
//   Channel  Ports                          Moves
//   input    in_valid, in_ready, in_data    one request (command, key, payload)
//   result   out_valid, out_ready, out_data one result per request
//
// A request is accepted, then the entries are scanned in order (up to
// entry_count, at least one examined), then the result is offered. A remove
// also shifts each later entry down. The single read port of the entry RAM
// sets this: entries are visited one per cycle.
// Reset is synchronous, active low, and clears the entry count; the RAM is not
// cleared since only entries below the count are ever used.
// The result buffer lets a new request be accepted while the previous result
// waits for out_ready; a stalled result stops the next hand-off and new requests.
`default_nettype none

module unique_key_table_compacting_unit
  import ukt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire ukt_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output ukt_out_t     out_data
);

  localparam int IDX_W = $clog2(CAPACITY);

  // Sequencer result hand-off.
  logic     res_valid;
  logic     res_ready;
  ukt_out_t res_data;

  // Entry RAM ports; each word holds the key above the payload.
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  // Output buffer.
  logic     out_valid_r, out_valid_nxt;
  ukt_out_t out_data_r, out_data_nxt;

  ukt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  ukt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The buffer takes a new result when it is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> bench/unique_key_table_compacting_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for unique_key_table_compacting_unit: drives lookup,
// add, remove and replace requests and checks every result against a predictor.
// Depends on ukt_pkg and the unique_key_table_compacting_unit RTL.

module unique_key_table_compacting_unit_tb;
  import ukt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  // One request costs at most accept + full scan + full shift + result. The
  // limit covers every request at that cost plus the receiver stalls and the
  // long hold-off, several times over.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 160;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ukt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ukt_out_t out_data;

  unique_key_table_compacting_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the table. It is updated at the edge where a request is
  // accepted, so it always reflects every request the block has taken in.
  logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
  logic [PAY_W-1:0] tbl_pays [TABLE_DEPTH];
  int               tbl_count = 0;

  // Results still owed by the block, oldest first.
  ukt_out_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  // The hold-off is requested by flipping hold_req; the receiver process
  // notices the flip and counts the stall down on its own.
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  ukt_out_t want;

  // Applies one request to the shadow table and returns the result the block
  // should give. The first matching key is taken, just as the block's sequencer
  // stops its scan at the first match.
  function automatic ukt_out_t table_apply(input ukt_in_t req);
    ukt_out_t res;
    int       pos;
    int       i;
    bit       hit;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    pos = 0;
    for (i = 0; i < tbl_count; i++) begin
      if (!hit && tbl_keys[i] == req.key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    case (req.command)
      CMD_LOOKUP: begin
        if (hit) begin
          res.found_payload = tbl_pays[pos];
          res.found_index = FIDX_W'(pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      CMD_ADD: begin
        // A duplicate is reported even when the table is full.
        if (hit) begin
          res.status = ST_DUPLICATE;
          res.found_index = FIDX_W'(pos);
        end else if (tbl_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_keys[tbl_count] = req.key;
          tbl_pays[tbl_count] = req.payload;
          res.found_index = FIDX_W'(tbl_count);
          tbl_count++;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i + 1];
            tbl_pays[i] = tbl_pays[i + 1];
          end
          tbl_count--;
          res.found_index = FIDX_W'(pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          tbl_pays[pos] = req.payload;
          res.found_index = FIDX_W'(pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
    endcase
    res.entry_count = ECNT_W'(tbl_count);
    return res;
  endfunction

  function automatic bit key_stored(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = $urandom; while (key_stored(k));
    return k;
  endfunction

  // Picks a key already in the table with the given odds, otherwise an edge
  // value now and then, otherwise a fully random one.
  function automatic logic [KEY_W-1:0] pick_key(input int stored_pct);
    int r;
    r = $urandom_range(99);
    if (r < stored_pct && tbl_count > 0) return tbl_keys[$urandom_range(tbl_count - 1)];
    if (r >= 90) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return {1'b1, {(KEY_W-1){1'b0}}};
        default: return {1'b0, {(KEY_W-1){1'b1}}};
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is
  // dropped only during a random gap, never in the step it is raised again.
  task automatic send_request(input ukt_cmd_t cmd, input logic [KEY_W-1:0] key,
                              input logic [PAY_W-1:0] payload);
    ukt_in_t req;
    req.command = cmd;
    req.key = key;
    req.payload = payload;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(table_apply(req));
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Every command on an empty table, the extreme keys and payloads, a
  // duplicate add, replace, and removal of the first, last and only entry.
  task automatic test_directed();
    send_request(CMD_LOOKUP, '0, '1);
    send_request(CMD_REMOVE, '1, '0);
    send_request(CMD_REPLACE, '0, 32'h1234_5678);
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_ADD, '1, '1);
    send_request(CMD_ADD, '0, 32'h1234_5678);
    send_request(CMD_ADD, 32'h8000_0000, 32'h8000_0001);
    send_request(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_LOOKUP, '0, '1);
    send_request(CMD_REPLACE, '1, 32'hA5A5_A5A5);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_LOOKUP, 32'h7FFF_FFFF, '0);
    send_request(CMD_REMOVE, 32'h7FFF_FFFF, '1);
    send_request(CMD_REMOVE, 32'h7FFF_FFFF, '1);
    send_request(CMD_REPLACE, 32'h0001_2345, '1);
    send_request(CMD_LOOKUP, 32'h8000_0000, '0);
    send_request(CMD_REMOVE, '1, '0);
    send_request(CMD_REMOVE, 32'h8000_0000, '0);
    send_request(CMD_LOOKUP, 32'h8000_0000, '0);
    send_request(CMD_ADD, 32'h0000_0001, 32'h5A5A_5A5A);
  endtask

  // Fills the table to capacity, then probes the full table: a new key is
  // refused, a present key is still reported as a duplicate, and the last slot
  // and the longest shift are exercised. Ends by thinning the table out.
  task automatic test_full_table();
    logic [KEY_W-1:0] k;
    while (tbl_count < TABLE_DEPTH) send_request(CMD_ADD, fresh_key(), pick_payload());
    send_request(CMD_ADD, fresh_key(), pick_payload());
    send_request(CMD_ADD, tbl_keys[0], pick_payload());
    send_request(CMD_ADD, tbl_keys[TABLE_DEPTH - 1], pick_payload());
    send_request(CMD_LOOKUP, tbl_keys[TABLE_DEPTH - 1], pick_payload());
    send_request(CMD_REPLACE, tbl_keys[TABLE_DEPTH - 1], '1);
    send_request(CMD_LOOKUP, tbl_keys[TABLE_DEPTH - 1], '0);
    k = tbl_keys[0];
    send_request(CMD_REMOVE, k, pick_payload());
    send_request(CMD_LOOKUP, k, pick_payload());
    send_request(CMD_ADD, fresh_key(), pick_payload());
    k = tbl_keys[TABLE_DEPTH - 1];
    send_request(CMD_REMOVE, k, pick_payload());
    send_request(CMD_REPLACE, k, pick_payload());
    while (tbl_count > TABLE_DEPTH / 2) begin
      send_request(CMD_REMOVE, tbl_keys[$urandom_range(tbl_count - 1)], pick_payload());
    end
  endtask

  // Random traffic in stretches that grow the table, shrink it, or keep it
  // level, so that both the full and the empty table are reached often.
  task automatic test_random(input int num_requests);
    int       j;
    int       r;
    int       add_pct;
    int       rem_pct;
    ukt_cmd_t cmd;
    for (j = 0; j < num_requests; j++) begin
      case ((j / 100) % 3)
        0: begin
          add_pct = 65;
          rem_pct = 10;
        end
        1: begin
          add_pct = 15;
          rem_pct = 55;
        end
        default: begin
          add_pct = 25;
          rem_pct = 25;
        end
      endcase
      r = $urandom_range(99);
      if (r < add_pct) cmd = CMD_ADD;
      else if (r < add_pct + rem_pct) cmd = CMD_REMOVE;
      else if (r < add_pct + rem_pct + (100 - add_pct - rem_pct) / 2) cmd = CMD_LOOKUP;
      else cmd = CMD_REPLACE;
      // Adds mostly bring new keys; the other commands mostly hit stored ones.
      send_request(cmd, pick_key(cmd == CMD_ADD ? 20 : 75), pick_payload());
    end
  endtask

  // Holds the receiver off long enough for the block to fill its result
  // buffer and stop taking requests, then lets everything drain with the
  // sender quiet.
  task automatic test_backpressure();
    int j;
    hold_req <= ~hold_req;
    for (j = 0; j < 16; j++) begin
      send_request(j % 2 ? CMD_LOOKUP : CMD_ADD, pick_key(50), pick_payload());
    end
    in_valid <= 1'b0;
    wait_for_drain();
  endtask

  // Receiver: random stalls, plus the long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (hold_left != 0 || hold_req != hold_seen) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: every result taken from the block is compared with the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        status_tally[want.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.found_payload !== want.found_payload) begin
          $error("found_payload: expected %h, got %h", want.found_payload,
                 out_data.found_payload);
          mismatches++;
        end
        if (out_data.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index,
                 out_data.found_index);
          mismatches++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("unique_key_table_compacting_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles less than the receiver first, then the other way round,
    // then both run flat out.
    set_idling(28, 53);
    test_directed();
    test_full_table();
    test_random(440);

    set_idling(53, 28);
    test_backpressure();
    test_random(440);

    set_idling(0, 0);
    test_random(440);

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked in %0d cycles", requests_sent,
             results_checked, cycle_count);
    $display("statuses: ok %0d, not found %0d, duplicate %0d, full %0d",
             status_tally[ST_OK], status_tally[ST_NOT_FOUND],
             status_tally[ST_DUPLICATE], status_tally[ST_FULL]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("unique_key_table_compacting_unit_tb: PASS");
    end else begin
      $display("unique_key_table_compacting_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ukt_pkg.sv
hdl/ukt_ram.sv
hdl/ukt_ctrl.sv
hdl/unique_key_table_compacting_unit.sv
bench/unique_key_table_compacting_unit_tb.sv
